>>> hdl/akvt_pkg.sv
// Package for the key-value table: command codes, port field widths and the
// control bundle passed from the controller to the datapath.
// No dependencies.
package akvt_pkg;

	localparam int CMD_W      = 3;
	localparam int KEY_PORT_W = 32;
	localparam int VAL_PORT_W = 32;
	localparam int CNT_PORT_W = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP = 3'd0,
		CMD_TOUCH  = 3'd1,
		CMD_WRITE  = 3'd2,
		CMD_REMOVE = 3'd3,
		CMD_CLEAR  = 3'd4
	} akvt_cmd_t;

	typedef struct packed {
		logic load;
		logic commit;
	} akvt_ctrl_t;

endpackage

>>> hdl/akvt_if.sv
// Channel interfaces of the key-value table: the command channel and the
// result channel, each with valid, ready and payload. Depends on akvt_pkg.
interface akvt_req_if import akvt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      cmd;
	logic [KEY_PORT_W-1:0] key;
	logic [VAL_PORT_W-1:0] value;

	modport source(output valid, output cmd, output key, output value, input ready);
	modport sink(input valid, input cmd, input key, input value, output ready);
endinterface

interface akvt_rsp_if import akvt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [VAL_PORT_W-1:0] value_out;
	logic                  found;
	logic                  full_error;
	logic [CNT_PORT_W-1:0] entry_count;

	modport source(output valid, output value_out, output found, output full_error,
		output entry_count, input ready);
	modport sink(input valid, input value_out, input found, input full_error,
		input entry_count, output ready);
endinterface

>>> hdl/array_key_value_table.sv
// Key-value table with unique keys held in insertion order.
// Top level; depends on akvt_pkg, akvt_if, akvt_ctrl and akvt_dp.
//
// Commands enter on the req channel (cmd, key, value) and each produces one
// transfer on the rsp channel (value_out, found, full_error, entry_count).
// Commands are lookup, lookup that inserts a zero value, write, remove and
// clear. Each command has two steps: in the cycle of its transfer every
// stored key is compared with it in parallel and the hit row is registered;
// in the update step that follows, the hit row is reduced, the table is
// updated (a remove shifts the later entries down by one) and the result
// register is loaded, and rsp is driven from that register. A new command is
// accepted only once the update of the last one is done, so commands do not
// overlap in the update step. If rsp stalls with a result held, the next
// command still enters and is compared, and its update waits until the held result is taken.
// Reset empties the table at once; stored entries need no clearing because
// only entries below the count are ever compared.
module array_key_value_table import akvt_pkg::*; #(
	parameter int CAPACITY = 64,
	parameter int KEY_W    = 32,
	parameter int VAL_W    = 32
) (
	input logic       clk,
	input logic       arst_n,
	akvt_req_if.sink  req,
	akvt_rsp_if.source rsp
);

	akvt_ctrl_t ctrl;

	akvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ctrl      (ctrl)
	);

	akvt_dp #(
		.CAPACITY (CAPACITY),
		.KEY_W    (KEY_W),
		.VAL_W    (VAL_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.cmd         (req.cmd),
		.key         (req.key),
		.value       (req.value),
		.value_out   (rsp.value_out),
		.found       (rsp.found),
		.full_error  (rsp.full_error),
		.entry_count (rsp.entry_count)
	);

endmodule

>>> hdl/akvt_ctrl.sv
// Controller of the key-value table: sequences compare and commit for each
// command and owns the result valid flag. Depends on akvt_pkg.
module akvt_ctrl import akvt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output akvt_ctrl_t ctrl
);

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	assign req_ready   = (state_q == ST_IDLE);
	assign ctrl.load   = req_valid && req_ready;
	assign ctrl.commit = (state_q == ST_BUSY) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid   = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctrl.load) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (ctrl.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (ctrl.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// A pending result is never overwritten before the sink takes it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_ready |-> !ctrl.commit)
		else $error("result overwritten while stalled");

	// Checks that no two transfers come back to back; one commit lies between them.
	a_load_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> !ctrl.load)
		else $error("command accepted during table update");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit |=> rsp_valid_q && !ctrl.commit)
		else $error("commit did not raise result valid");

endmodule

>>> hdl/akvt_dp.sv
// Datapath of the key-value table: a row of key/value cells compared in
// parallel, the update and shift logic and the result register. Depends on akvt_pkg.
module akvt_dp import akvt_pkg::*; #(
	parameter int CAPACITY = 64,
	parameter int KEY_W    = 32,
	parameter int VAL_W    = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  akvt_ctrl_t            ctrl,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [KEY_PORT_W-1:0] key,
	input  logic [VAL_PORT_W-1:0] value,
	output logic [VAL_PORT_W-1:0] value_out,
	output logic                  found,
	output logic                  full_error,
	output logic [CNT_PORT_W-1:0] entry_count
);

	localparam int KS_W = (KEY_W < KEY_PORT_W) ? KEY_W : KEY_PORT_W;
	localparam int VS_W = (VAL_W < VAL_PORT_W) ? VAL_W : VAL_PORT_W;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int IW   = $clog2(CAPACITY);

	logic [KS_W-1:0]     key_q [CAPACITY];
	logic [VS_W-1:0]     val_q [CAPACITY];
	logic [CW-1:0]       count_q;

	akvt_cmd_t           cmd_s1;
	logic [KS_W-1:0]     key_s1;
	logic [VS_W-1:0]     val_s1;
	logic [CAPACITY-1:0] hit_s1;

	logic                hit_any;
	logic [IW-1:0]       hit_idx;
	logic [VS_W-1:0]     hit_val;
	logic                is_full;
	logic                do_append;
	logic [VS_W-1:0]     append_val;
	logic                do_wr_hit;
	logic                do_remove;
	logic [VS_W-1:0]     vout;
	logic                found_r;
	logic                err_r;
	logic [CW-1:0]       count_nxt;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_s1 <= akvt_cmd_t'(cmd);
			key_s1 <= key[KS_W-1:0];
			val_s1 <= value[VS_W-1:0];
			for (int i = 0; i < CAPACITY; i++) begin
				hit_s1[i] <= (CW'(i) < count_q) && (key_q[i] == key[KS_W-1:0]);
			end
		end
	end

	// Keys are unique, so at most one hit bit is set and an OR tree selects it.
	always_comb begin
		hit_idx = '0;
		hit_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit_s1[i]) begin
				hit_idx = hit_idx | IW'(i);
				hit_val = hit_val | val_q[i];
			end
		end
	end

	always_comb begin
		hit_any    = |hit_s1;
		is_full    = (count_q == CW'(CAPACITY));
		do_append  = 1'b0;
		append_val = '0;
		do_wr_hit  = 1'b0;
		do_remove  = 1'b0;
		vout       = '0;
		found_r    = hit_any;
		err_r      = 1'b0;
		count_nxt  = count_q;
		unique case (cmd_s1)
			CMD_LOOKUP: begin
				if (hit_any) begin
					vout = hit_val;
				end
			end
			CMD_TOUCH: begin
				if (hit_any) begin
					vout = hit_val;
				end else if (is_full) begin
					err_r = 1'b1;
				end else begin
					do_append = 1'b1;
					count_nxt = count_q + CW'(1);
				end
			end
			CMD_WRITE: begin
				if (hit_any) begin
					do_wr_hit = 1'b1;
				end else if (is_full) begin
					err_r = 1'b1;
				end else begin
					do_append  = 1'b1;
					append_val = val_s1;
					count_nxt  = count_q + CW'(1);
				end
			end
			CMD_REMOVE: begin
				if (hit_any) begin
					do_remove = 1'b1;
					count_nxt = count_q - CW'(1);
				end
			end
			CMD_CLEAR: begin
				found_r   = 1'b0;
				count_nxt = '0;
			end
			default: begin
				found_r = 1'b0;
			end
		endcase
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (ctrl.commit) begin
				if (do_append && (CW'(g) == count_q)) begin
					key_q[g] <= key_s1;
					val_q[g] <= append_val;
				end else if (do_wr_hit && hit_s1[g]) begin
					val_q[g] <= val_s1;
				end else if (do_remove && (IW'(g) >= hit_idx)) begin
					if (g < CAPACITY - 1) begin
						key_q[g] <= key_q[(g + 1) % CAPACITY];
						val_q[g] <= val_q[(g + 1) % CAPACITY];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.commit) begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			value_out   <= VAL_PORT_W'(vout);
			found       <= found_r;
			full_error  <= err_r;
			entry_count <= CNT_PORT_W'(count_nxt);
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_err_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit && err_r |-> is_full && !hit_any)
		else $error("full error on a table with room");

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit |-> $onehot0(hit_s1))
		else $error("duplicate key in table");

endmodule
